// ===== src/vidc_pkg.sv =====
package vidc_pkg;

    localparam int CACHE_SLOTS_DEF = 256;
    localparam int FETCH_LIMIT_DEF = 256;
    localparam int DRAW_LIMIT_DEF  = 16384;

    localparam int DRAW_MARGIN  = 6;
    localparam int FETCH_MARGIN = 4;

    // batch generation tag kept with every slot; generation 0 marks a cleared slot
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic        func;
        logic [31:0] vertex_index;
        logic [15:0] flags;
        logic        prim_end;
    } t_in;

    typedef struct packed {
        logic [15:0] draw_word;
        logic        slot_miss;
        logic [7:0]  fetch_slot;
        logic [31:0] fetch_vertex;
        logic        batch_flushed;
        logic [8:0]  batch_fetch_count;
        logic [14:0] batch_draw_count;
        logic        overflow_error;
    } t_out;

    typedef struct packed {
        logic capture;
        logic mul;
        logic read;
        logic lookup;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic need_clear;
        logic clear_last;
    } t_sts;

endpackage

// ===== src/vidc_ctrl.sv =====
module vidc_ctrl
    import vidc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_IDX   = 5'b00100,
        S_LOOK  = 5'b01000,
        S_CLEAR = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_start;
                if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_IDX;
            end
            S_IDX: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_sts.need_clear ? S_CLEAR : S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== src/vidc_dp.sv =====
module vidc_dp
    import vidc_pkg::*;
#(
    parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
    parameter int FETCH_LIMIT = FETCH_LIMIT_DEF,
    parameter int DRAW_LIMIT  = DRAW_LIMIT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_done,
    output t_out o_result
);

    localparam int IW  = $clog2(CACHE_SLOTS);
    localparam int FNW = $clog2(FETCH_LIMIT);
    localparam int FCW = $clog2(FETCH_LIMIT + 1);
    localparam int DCW = $clog2(DRAW_LIMIT + 1);
    // floor(2^32 / slots): quotient estimate is exact or one low
    localparam logic [63:0] RECIP = 64'h1_0000_0000 / 64'(CACHE_SLOTS);

    // slot store
    logic [31:0]        mem_tag [CACHE_SLOTS];
    logic [EPOCH_W-1:0] mem_ep  [CACHE_SLOTS];
    logic [FNW-1:0]     mem_fn  [CACHE_SLOTS];

    logic               r_func;
    logic [31:0]        r_vtx;
    logic [15:0]        r_flags;
    logic               r_pend;
    logic [31:0]        r_q;
    logic [31:0]        r_prod;
    logic [IW-1:0]      r_idx;
    logic [31:0]        r_rd_tag;
    logic [EPOCH_W-1:0] r_rd_ep;
    logic [FNW-1:0]     r_rd_fn;
    logic [EPOCH_W-1:0] r_epoch;
    logic [FCW-1:0]     r_fetched;
    logic [DCW-1:0]     r_drawn;
    logic [IW-1:0]      r_clr_addr;
    logic               r_done;
    t_out               r_out;

    logic [63:0]    qprod;
    logic [31:0]    rem;
    logic [IW-1:0]  idx;
    logic           hit;
    logic           full;
    logic           ovf;
    logic           fill;
    logic [FNW-1:0] fnum;
    logic [FCW-1:0] n_fetched;
    logic [DCW-1:0] n_drawn;
    logic           flush;
    t_out           n_out;

    assign qprod = 64'(i_item.vertex_index) * RECIP;

    always_comb begin
        rem = r_vtx - r_prod;
        if (rem >= 32'(CACHE_SLOTS)) begin
            rem = rem - 32'(CACHE_SLOTS);
        end
        idx = IW'(rem);
    end

    always_comb begin
        hit  = (r_rd_ep == r_epoch) && (r_rd_tag == r_vtx);
        full = (r_fetched >= FCW'(FETCH_LIMIT));
        ovf  = !r_func && !hit && full;
        fill = !r_func && !hit && !full;
        fnum = fill ? FNW'(r_fetched) : r_rd_fn;
        n_fetched = fill ? r_fetched + 1'b1 : r_fetched;
        n_drawn   = r_drawn;
        if (!r_func && !ovf && (r_drawn < DCW'(DRAW_LIMIT))) begin
            n_drawn = r_drawn + 1'b1;
        end
        flush = r_func || (r_pend &&
                ((32'(n_drawn) + 32'(DRAW_MARGIN) >= 32'(DRAW_LIMIT)) ||
                 (32'(n_fetched) + 32'(FETCH_MARGIN) >= 32'(FETCH_LIMIT))));

        n_out                   = '0;
        n_out.draw_word         = (r_func || ovf) ? 16'd0 : (16'(fnum) | r_flags);
        n_out.slot_miss         = fill;
        n_out.fetch_slot        = fill ? 8'(r_fetched) : 8'd0;
        n_out.fetch_vertex      = fill ? r_vtx : 32'd0;
        n_out.overflow_error    = ovf;
        n_out.batch_flushed     = flush;
        n_out.batch_fetch_count = flush ? 9'(n_fetched) : 9'd0;
        n_out.batch_draw_count  = flush ? 15'(n_drawn) : 15'd0;
    end

    assign o_sts.need_clear = flush && (r_epoch == '1);
    assign o_sts.clear_last = (r_clr_addr == IW'(CACHE_SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_item.func;
            r_vtx   <= i_item.vertex_index;
            r_flags <= i_item.flags;
            r_pend  <= i_item.prim_end;
            r_q     <= qprod[63:32];
        end
        if (i_cmd.mul) begin
            r_prod <= r_q * 32'(CACHE_SLOTS);
        end
        if (i_cmd.read) begin
            r_idx    <= idx;
            r_rd_tag <= mem_tag[idx];
            r_rd_ep  <= mem_ep[idx];
            r_rd_fn  <= mem_fn[idx];
        end
        if (i_cmd.lookup) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_ep[r_clr_addr] <= '0;
        end else if (i_cmd.lookup && fill) begin
            mem_tag[r_idx] <= r_vtx;
            mem_ep[r_idx]  <= r_epoch;
            mem_fn[r_idx]  <= fnum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch    <= EPOCH_W'(1);
            r_fetched  <= '0;
            r_drawn    <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.lookup;
            if (i_cmd.clear) begin
                r_clr_addr <= o_sts.clear_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.lookup) begin
                if (flush) begin
                    r_fetched <= '0;
                    r_drawn   <= '0;
                    // generation wrap: restart at 1, a clearing pass follows
                    r_epoch   <= (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + 1'b1;
                end else begin
                    r_fetched <= n_fetched;
                    r_drawn   <= n_drawn;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// ===== src/vertex_index_dedup_cache.sv =====
// Vertex index dedup cache. An item is taken when start is high and busy is low. Its result
// appears on o_result with o_done after the MUL, IDX and LOOK states. It cannot be held off,
// so the receiver must take it in that cycle. A new item is not taken until the last one has
// passed these steps:
//   - the reciprocal multiply for the slot number (vertex index mod CACHE_SLOTS) runs in the
//     accepting cycle;
//   - the multiply-back runs in the next cycle;
//   - the IDX state finishes the remainder and reads the slot store;
//   - the LOOK state compares and updates the slot store.
// busy normally drops in the cycle the result is shown. After reset, busy stays high for a
// clearing pass over every slot. The same pass follows every 255th batch flush, when the
// 8-bit batch generation tag wraps. That flush's result is still shown on time, while busy
// stays high through the pass.
module vertex_index_dedup_cache
    import vidc_pkg::*;
#(
    parameter int CACHE_SLOTS = CACHE_SLOTS_DEF,
    parameter int FETCH_LIMIT = FETCH_LIMIT_DEF,
    parameter int DRAW_LIMIT  = DRAW_LIMIT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_done,
    output t_out o_result
);

    t_cmd cmd;
    t_sts sts;

    vidc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    vidc_dp #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .FETCH_LIMIT (FETCH_LIMIT),
        .DRAW_LIMIT  (DRAW_LIMIT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("result not delivered four cycles after accept");

endmodule
